/* rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers for the pad report decoder. Defining
// NO_ASSERTIONS leaves every use empty.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Assertion on an explicit clock and active-low reset.
`define OPRD_ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// Assertion on the block's own clock and reset.
`define OPRD_ASSERT(lbl, prop, msg) \
  `OPRD_ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)

`else

`define OPRD_ASSERT_CLK(lbl, clk, rst_n, prop, msg)
`define OPRD_ASSERT(lbl, prop, msg)

`endif

`endif

/* rtl/oprd_pkg.sv */
// ----------------------------------------------------------------------------
// Pad report decoder package
// Shared constants, word types and register codes.
// ----------------------------------------------------------------------------
package oprd_pkg;

  localparam int unsigned REPORT_BYTES = 8;
  localparam int unsigned POS_W        = $clog2(REPORT_BYTES);
  localparam int unsigned THR_W        = 3;
  localparam int unsigned BYTE_W       = 8;
  localparam int unsigned PARTIAL_W    = 6;
  localparam int unsigned IDX_W        = 3;

  localparam logic [THR_W-1:0]  THRESHOLD_RST = 3'd2;
  localparam logic [BYTE_W-1:0] HEADER_RST    = 8'h11;
  localparam logic [BYTE_W-1:0] ADJ_BIAS      = 8'h7f;
  localparam logic [1:0]        QUARTER_LAST  = 2'd3;

  localparam logic [POS_W-1:0] LAST_POS  = POS_W'(REPORT_BYTES - 1);
  localparam logic [POS_W-1:0] POS_ADD_A = POS_W'(2);
  localparam logic [POS_W-1:0] POS_ADD_B = POS_W'(4);
  localparam logic [POS_W-1:0] POS_SUB_A = POS_W'(3);
  localparam logic [POS_W-1:0] POS_SUB_B = POS_W'(5);
  localparam logic [IDX_W-1:0] LAST_IDX  = LAST_POS[IDX_W-1:0];

  typedef enum logic [0:0] {
    CFG_VOTE_THRESHOLD = 1'b0,
    CFG_HEADER_PATTERN = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic [BYTE_W-1:0] sample_byte;
    logic              frame_start;
  } in_word_t;

  typedef struct packed {
    logic [BYTE_W-1:0] report_byte;
    logic [IDX_W-1:0]  byte_index;
    logic              last_byte;
    logic              frame_ok;
  } out_word_t;

endpackage

/* rtl/oprd_pair_decode.sv */
// ----------------------------------------------------------------------------
// Bit pair decoder
// Weighted 1-2-2-1 vote over each sample nibble against the threshold.
// ----------------------------------------------------------------------------
module oprd_pair_decode (
  input  logic [oprd_pkg::BYTE_W-1:0] sample_i,
  input  logic [oprd_pkg::THR_W-1:0]  thr_i,
  output logic [1:0]                  pair_o
);

  logic [2:0] sum_lo;
  logic [2:0] sum_hi;

  // outer samples weigh 1, middle ones 2; max sum 6
  assign sum_lo = 3'(sample_i[0]) + {1'b0, sample_i[1], 1'b0}
                + {1'b0, sample_i[2], 1'b0} + 3'(sample_i[3]);
  assign sum_hi = 3'(sample_i[4]) + {1'b0, sample_i[5], 1'b0}
                + {1'b0, sample_i[6], 1'b0} + 3'(sample_i[7]);

  assign pair_o = {sum_hi > thr_i, sum_lo > thr_i};

endmodule

/* rtl/oprd_byte_builder.sv */
// ----------------------------------------------------------------------------
// Report byte builder
// Collects four bit pairs per report byte, tracks position and header
// check, and applies the per-position offset.
// ----------------------------------------------------------------------------
module oprd_byte_builder (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        step_i,
  input  oprd_pkg::in_word_t          word_i,
  input  logic [1:0]                  pair_i,
  input  logic [oprd_pkg::BYTE_W-1:0] hdr_i,
  output logic                        emit_o,
  output oprd_pkg::out_word_t         res_o
);

  logic [1:0]                           qc_q, qc_d, qc_eff;
  logic [oprd_pkg::POS_W-1:0]           pos_q, pos_d, pos_eff;
  logic [oprd_pkg::PARTIAL_W-1:0]       part_q, part_d, part_eff;
  logic                                 hm_q, hm_d, hm_eff;
  logic [oprd_pkg::BYTE_W-1:0]          raw;
  logic [oprd_pkg::BYTE_W-1:0]          adj;

  // frame start clears the byte state before this word is decoded
  always_comb begin
    if (word_i.frame_start) begin
      qc_eff   = '0;
      pos_eff  = '0;
      part_eff = '0;
      hm_eff   = (word_i.sample_byte == hdr_i);
    end else begin
      qc_eff   = qc_q;
      pos_eff  = pos_q;
      part_eff = part_q;
      hm_eff   = hm_q;
    end
  end

  assign emit_o = (qc_eff == oprd_pkg::QUARTER_LAST);
  assign raw    = {part_eff, pair_i};

  always_comb begin
    if (pos_eff == oprd_pkg::POS_ADD_A || pos_eff == oprd_pkg::POS_ADD_B) begin
      adj = raw + oprd_pkg::ADJ_BIAS;
    end else if (pos_eff == oprd_pkg::POS_SUB_A || pos_eff == oprd_pkg::POS_SUB_B) begin
      adj = oprd_pkg::ADJ_BIAS - raw;
    end else begin
      adj = raw;
    end
  end

  always_comb begin
    res_o.report_byte = adj;
    res_o.byte_index  = pos_eff[oprd_pkg::IDX_W-1:0];
    res_o.last_byte   = (pos_eff == oprd_pkg::LAST_POS);
    res_o.frame_ok    = hm_eff;
  end

  always_comb begin
    hm_d = hm_eff;
    if (emit_o) begin
      qc_d   = '0;
      part_d = '0;
      pos_d  = (pos_eff == oprd_pkg::LAST_POS) ? '0 : pos_eff + oprd_pkg::POS_W'(1);
    end else begin
      qc_d   = qc_eff + 2'd1;
      part_d = {part_eff[oprd_pkg::PARTIAL_W-3:0], pair_i};
      pos_d  = pos_eff;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      qc_q   <= '0;
      pos_q  <= '0;
      part_q <= '0;
      hm_q   <= 1'b0;
    end else if (step_i) begin
      qc_q   <= qc_d;
      pos_q  <= pos_d;
      part_q <= part_d;
      hm_q   <= hm_d;
    end
  end

endmodule

/* rtl/oversampled_pad_report_decoder_core.sv */
// ----------------------------------------------------------------------------
// Oversampled pad report decoder core
// Decodes raw sample bytes (two 4x oversampled line bits each) into
// adjusted report bytes, four sample words to one report word.
// ----------------------------------------------------------------------------
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+-------------------------
//  in      | input     | in_valid_i/in_ready_o | in_data_i (in_word_t)
//  out     | output    | out_valid_o/out_ready_i | out_data_o (out_word_t)
//  cfg     | input     | cfg_we_i              | cfg_idx_i, cfg_wdata_i
//
//  One sample word accepted per cycle unless stalled; a report word passes
//  the input and result registers once its fourth sample word is accepted.
//  Rate is set by the input register feeding the decode/build logic and
//  the result register behind it: each advances once per cycle unless stalled.
//  Reset clears both stage valids, the byte state and loads register
//  defaults (threshold 2, header 0x11).
//  A stalled output holds the result register; the input register then
//  fills and in_ready_o drops until the result is taken.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module oversampled_pad_report_decoder_core (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // sample input
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  oprd_pkg::in_word_t          in_data_i,
  // report output
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output oprd_pkg::out_word_t         out_data_o,
  // configuration
  input  logic                        cfg_we_i,
  input  oprd_pkg::cfg_reg_e          cfg_idx_i,
  input  logic [oprd_pkg::BYTE_W-1:0] cfg_wdata_i
);

  // configuration registers
  logic [oprd_pkg::THR_W-1:0]  thr_q;
  logic [oprd_pkg::BYTE_W-1:0] hdr_q;

  // input register
  logic                 s1_valid_q, s1_valid_d;
  oprd_pkg::in_word_t   s1_word_q;
  logic                 s1_adv;

  // result register
  logic                 out_valid_q, out_valid_d;
  oprd_pkg::out_word_t  out_word_q;

  logic                 emit;
  logic [1:0]           pair;
  oprd_pkg::out_word_t  res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= oprd_pkg::THRESHOLD_RST;
      hdr_q <= oprd_pkg::HEADER_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        oprd_pkg::CFG_VOTE_THRESHOLD: thr_q <= cfg_wdata_i[oprd_pkg::THR_W-1:0];
        oprd_pkg::CFG_HEADER_PATTERN: hdr_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // the held word moves on once the result register can take a word
  assign s1_adv     = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || s1_adv;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_ready_o) begin
      s1_valid_d = in_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      s1_word_q <= in_data_i;
    end
  end

  oprd_pair_decode u_pair (
    .sample_i (s1_word_q.sample_byte),
    .thr_i    (thr_q),
    .pair_o   (pair)
  );

  oprd_byte_builder u_build (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (s1_adv),
    .word_i (s1_word_q),
    .pair_i (pair),
    .hdr_i  (hdr_q),
    .emit_o (emit),
    .res_o  (res)
  );

  // only the fourth sample word of a group loads a result
  always_comb begin
    out_valid_d = out_valid_q && !out_ready_i;
    if (s1_adv && emit) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && emit) begin
      out_word_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_word_q;

  // ready only drops behind a full input register and a stalled result
  `OPRD_ASSERT(a_ready_low_cause,
    !in_ready_o |-> (s1_valid_q && out_valid_q && !out_ready_i),
    "input stalled without a blocked result")

  // a held word that cannot move is still held next cycle
  `OPRD_ASSERT(a_s1_hold,
    (s1_valid_q && !s1_adv) |=> s1_valid_q,
    "input register dropped a word")

  // last word flag only at the final report position
  `OPRD_ASSERT(a_last_index,
    (out_valid_o && out_data_o.last_byte) |-> (out_data_o.byte_index == oprd_pkg::LAST_IDX),
    "last word flag at wrong position")

endmodule

/* dv/tb.sv */
// ----------------------------------------------------------------------------
// Pad report decoder testbench
// Drives sample words with random gaps and output back-pressure. A local
// behavioural predictor of the vote, assembly and adjust logic runs on every
// accepted sample word. Each report word is checked field by field against
// the oldest prediction as it leaves the core.
// ----------------------------------------------------------------------------
module tb;
  import oprd_pkg::*;

  localparam int unsigned HALF_PERIOD      = 10;
  localparam int unsigned RESET_CYCLES     = 8;
  localparam int unsigned SETTLE_CYCLES    = 6;       // two-stage pipe plus margin
  localparam int unsigned CYCLE_LIMIT      = 200000;
  localparam int unsigned MAX_GAP          = 6;
  localparam int unsigned LONG_HOLD        = 120;
  localparam int unsigned MAX_PRINTS       = 40;
  localparam int unsigned RANDOM_ITEMS     = 270;
  localparam int unsigned SWEEP_PHASES     = 6;
  localparam int unsigned SAMPLES_PER_BYTE = 4;
  localparam int unsigned FRAME_SAMPLES    = REPORT_BYTES * SAMPLES_PER_BYTE;

  // report adjustment: positions 2/4 add the bias, 3/5 subtract from it
  localparam logic [7:0]  BIAS      = 8'd127;
  localparam int unsigned ADD_POS_A = 2;
  localparam int unsigned ADD_POS_B = 4;
  localparam int unsigned SUB_POS_A = 3;
  localparam int unsigned SUB_POS_B = 5;

  localparam logic [2:0] THR_DEFAULT = 3'd2;
  localparam logic [7:0] HDR_DEFAULT = 8'h11;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_ready;
  in_word_t   in_data;
  logic       out_valid;
  logic       out_ready;
  out_word_t  out_data;
  logic       cfg_we;
  cfg_reg_e   cfg_idx;
  logic [7:0] cfg_wdata;

  // predictor copy of the registers and the decode state
  logic [2:0]  thr_q       = THR_DEFAULT;
  logic [7:0]  hdr_q       = HDR_DEFAULT;
  int unsigned quarters    = 0;
  int unsigned position    = 0;
  logic [5:0]  partial     = '0;
  logic        hdr_hit     = 1'b0;

  out_word_t   report_q[$];              // report words still to come out
  int unsigned mismatches  = 0;
  int unsigned cycles      = 0;

  // pacing controls shared between the tests and the two drivers
  bit          tx_burst    = 1'b0;       // sender: no gaps
  bit          rx_burst    = 1'b0;       // receiver: no stalls
  int unsigned rx_hold     = 0;          // one-off long receiver hold

  oversampled_pad_report_decoder_core i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  initial clk = 1'b0;
  always #HALF_PERIOD clk = ~clk;

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------

  // Weighted vote over four samples, outer ones weigh 1 and middle ones 2.
  function automatic logic vote_bit(logic [3:0] n);
    int unsigned sum;
    sum = n[0] + 2 * n[1] + 2 * n[2] + n[3];
    return sum > thr_q;
  endfunction

  // Advance the decode state by one accepted sample word; every fourth word
  // of a group yields one report word.
  function automatic void decode_sample(in_word_t w);
    logic [1:0] pair;
    logic [7:0] val;
    out_word_t  rep;
    if (w.frame_start) begin
      quarters = 0;
      position = 0;
      partial  = '0;
      hdr_hit  = (w.sample_byte == hdr_q);
    end
    // high nibble carries the more significant bit of the pair
    pair = {vote_bit(w.sample_byte[7:4]), vote_bit(w.sample_byte[3:0])};
    if (quarters < SAMPLES_PER_BYTE - 1) begin
      partial  = {partial[3:0], pair};
      quarters = quarters + 1;
      return;
    end
    val = {partial, pair};
    if (position == ADD_POS_A || position == ADD_POS_B) begin
      val = val + BIAS;
    end else if (position == SUB_POS_A || position == SUB_POS_B) begin
      val = BIAS - val;
    end
    rep.report_byte = val;
    rep.byte_index  = 3'(position);
    rep.last_byte   = (position == REPORT_BYTES - 1);
    rep.frame_ok    = hdr_hit;
    report_q.push_back(rep);
    quarters = 0;
    partial  = '0;
    // past the last byte the report starts again, header flag kept
    position = (position >= REPORT_BYTES - 1) ? 0 : position + 1;
  endfunction

  // --------------------------------------------------------------------------
  // Checking
  // --------------------------------------------------------------------------

  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    mismatches++;
    if (mismatches <= MAX_PRINTS) begin
      $display("[%0t] %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
    end
  endtask

  task automatic check_report(out_word_t got);
    out_word_t want;
    if (report_q.size() == 0) begin
      report_mismatch("report word with none expected", got, 0);
      return;
    end
    want = report_q.pop_front();
    if (got.report_byte !== want.report_byte) begin
      report_mismatch("report_byte", got.report_byte, want.report_byte);
    end
    if (got.byte_index !== want.byte_index) begin
      report_mismatch("byte_index", got.byte_index, want.byte_index);
    end
    if (got.last_byte !== want.last_byte) begin
      report_mismatch("last_byte", got.last_byte, want.last_byte);
    end
    if (got.frame_ok !== want.frame_ok) begin
      report_mismatch("frame_ok", got.frame_ok, want.frame_ok);
    end
  endtask

  // Everything is sampled at the rising edge; inputs only move on the
  // falling edge, so values read here are the ones the core sees.
  always @(posedge clk) begin
    cycles++;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        check_report(out_data);
      end
      if (in_valid && in_ready) begin
        decode_sample(in_data);
      end
    end
    if (cycles > CYCLE_LIMIT) begin
      $display("[%0t] timeout, %0d report words outstanding", $time, report_q.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Receiver: draws a stall before each report word, or takes a one-off
  // long hold when a test asks for it.
  // --------------------------------------------------------------------------
  initial begin : receiver
    int unsigned stall;
    out_ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      stall = rx_burst ? 0 : $urandom_range(0, MAX_GAP);
      if (rx_hold != 0) begin
        stall   = rx_hold;
        rx_hold = 0;
      end
      if (stall != 0) begin
        @(negedge clk);
        out_ready <= 1'b0;
        repeat (stall - 1) @(negedge clk);
      end
      @(negedge clk);
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  // --------------------------------------------------------------------------
  // Sender and helpers
  // --------------------------------------------------------------------------

  // Offer one sample word after a random gap, or none in burst mode; returns at the accepting edge.
  task automatic send_sample(logic [7:0] sample, logic start);
    int unsigned gap;
    in_word_t    w;
    gap = tx_burst ? 0 : $urandom_range(0, MAX_GAP);
    w.sample_byte = sample;
    w.frame_start = start;
    if (gap != 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (!in_ready);
  endtask

  // A frame of n sample words; the first optionally carries the header.
  task automatic send_frame(int unsigned n, bit hit);
    logic [7:0] sample;
    for (int unsigned i = 0; i < n; i++) begin
      sample = $urandom;
      if (i == 0 && hit) begin
        sample = hdr_q;
      end
      send_sample(sample, i == 0);
    end
  endtask

  // Stop offering, wait for all outstanding report words, then let the
  // pipe empty of partial groups that produce nothing.
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (report_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Register write; only called with the core idle, so the predictor copy
  // can follow straight away.
  task automatic write_reg(cfg_reg_e idx, logic [7:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    @(negedge clk);
    cfg_we    <= 1'b0;
    case (idx)
      CFG_VOTE_THRESHOLD: thr_q = data[2:0];
      CFG_HEADER_PATTERN: hdr_q = data;
      default: ;
    endcase
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Default settings: words ahead of any frame start, a matched frame with
  // vote edge cases, a frame cut short by an unmatched restart.
  task automatic test_directed();
    logic [7:0] pre   [4]  = '{8'h00, 8'hff, 8'h0f, 8'hf0};
    logic [7:0] frame [12] = '{8'h11, 8'h66, 8'h99, 8'hff, 8'h00, 8'h12,
                               8'h21, 8'h48, 8'h84, 8'hee, 8'h77, 8'h5a};
    foreach (pre[i]) send_sample(pre[i], 1'b0);
    foreach (frame[i]) send_sample(frame[i], i == 0);
    send_sample(8'h3c, 1'b0);
    send_sample(8'hc3, 1'b0);
    // restart mid-report with a header that misses
    send_sample(8'h10, 1'b1);
    repeat (6) send_sample($urandom, 1'b0);
  endtask

  // Threshold and header extremes, then random settings; each phase runs
  // matched, unmatched and wrapping frames.
  task automatic test_config_sweep();
    logic [2:0] thr;
    logic [7:0] hdr;
    logic [7:0] data;
    for (int unsigned ph = 0; ph < SWEEP_PHASES; ph++) begin
      thr = $urandom;
      hdr = $urandom;
      case (ph)
        0: begin
          thr = 3'd0;
          hdr = 8'h00;
        end
        1: begin
          thr = 3'd7;                    // nothing can beat it: all zero
          hdr = 8'hff;
        end
        2: thr = 3'd6;
        default: ;
      endcase
      settle();
      data      = $urandom;              // upper bits are don't-care
      data[2:0] = thr;
      write_reg(CFG_VOTE_THRESHOLD, data);
      write_reg(CFG_HEADER_PATTERN, hdr);
      send_frame(FRAME_SAMPLES, 1'b1);
      send_frame(FRAME_SAMPLES, 1'b0);
      send_frame($urandom_range(FRAME_SAMPLES + 1, FRAME_SAMPLES + 12), $urandom_range(0, 1));
    end
  endtask

  // Mostly whole frames, some overrunning the report, some truncated, and
  // loose noise words with the odd stray frame start.
  task automatic test_random_frames();
    int unsigned sent;
    int unsigned kind;
    int unsigned n;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      tx_burst = ($urandom_range(0, 3) == 0);
      rx_burst = ($urandom_range(0, 3) == 0);
      kind     = $urandom_range(0, 9);
      if (kind < 6) begin
        n = FRAME_SAMPLES;
        if ($urandom_range(0, 3) == 0) begin
          n = n + $urandom_range(1, FRAME_SAMPLES + 7);
        end
        send_frame(n, $urandom_range(0, 3) != 0);
      end else if (kind < 8) begin
        n = $urandom_range(1, FRAME_SAMPLES - 1);
        send_frame(n, $urandom_range(0, 1));
      end else begin
        n = $urandom_range(1, 10);
        repeat (n) send_sample($urandom, $urandom_range(0, 7) == 0);
      end
      sent += n;
    end
    tx_burst = 1'b0;
    rx_burst = 1'b0;
  endtask

  // Receiver holds off for a long stretch while words keep coming back to
  // back, so the core fills and drops its input ready.
  task automatic test_output_stall();
    settle();
    rx_hold  = LONG_HOLD;
    tx_burst = 1'b1;
    send_frame(FRAME_SAMPLES + 8, 1'b1);
    tx_burst = 1'b0;
  endtask

  // Sender stops after each frame until every report word is out.
  task automatic test_drain_pause();
    repeat (4) begin
      send_frame($urandom_range(SAMPLES_PER_BYTE, FRAME_SAMPLES + 8), 1'b1);
      @(negedge clk);
      in_valid <= 1'b0;
      while (report_q.size() != 0) @(posedge clk);
    end
  endtask

  initial begin
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_we    = 1'b0;
    cfg_idx   = CFG_VOTE_THRESHOLD;
    cfg_wdata = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_config_sweep();
    test_random_frames();
    test_output_stall();
    test_drain_pause();
    settle();

    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+rtl
rtl/oprd_pkg.sv
rtl/oprd_pair_decode.sv
rtl/oprd_byte_builder.sv
rtl/oversampled_pad_report_decoder_core.sv
dv/tb.sv
